/* hw/rtl/bass_pkg.sv */
// types, constants and microcode program of the burst ack stream sender
package bass_pkg;

    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_ACK_TIMEOUT = 1'b0;
    localparam logic [31:0] ACK_TIMEOUT_RESET = 32'd1000;
    // retry count at which the next no-progress event ends the write
    localparam logic [1:0] RETRY_FINAL = 2'd2;

    typedef enum logic [2:0] {
        KIND_FRAME      = 3'd0,
        KIND_DONE       = 3'd1,
        KIND_BAD_STATE  = 3'd2,
        KIND_TIMEOUT    = 3'd3,
        KIND_OUT_OF_SEQ = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_DECODE,
        U_REPORT,
        U_START,
        U_BURST,
        U_FRAME,
        U_TICK,
        U_RETRY,
        U_MATCH,
        U_FINISH
    } t_uop;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_TICK_WAIT,
        C_ACK_ADVANCED,
        C_RETRY_LEFT,
        C_NO_HIT,
        C_NOT_DONE,
        C_MORE_FRAMES
    } t_ucond;

    typedef enum logic [2:0] {
        D_IDLE,
        D_BAD,
        D_ZERO,
        D_START,
        D_RESOLVE,
        D_TICK
    } t_disp;

    typedef logic [4:0] t_upc;

    localparam t_upc P_FETCH     = 5'd0;
    localparam t_upc P_DECODE    = 5'd1;
    localparam t_upc P_BAD       = 5'd2;
    localparam t_upc P_ZERO      = 5'd3;
    localparam t_upc P_START     = 5'd4;
    localparam t_upc P_BURST     = 5'd5;
    localparam t_upc P_EMIT      = 5'd6;
    localparam t_upc P_BURST_END = 5'd7;
    localparam t_upc P_TICK      = 5'd8;
    localparam t_upc P_TICK_CHK  = 5'd9;
    localparam t_upc P_RESOLVE   = 5'd10;
    localparam t_upc P_RETRY     = 5'd11;
    localparam t_upc P_TIMEOUT   = 5'd12;
    localparam t_upc P_MATCH     = 5'd13;
    localparam t_upc P_DONE_CHK  = 5'd14;
    localparam t_upc P_DONE      = 5'd15;
    localparam t_upc P_OOS       = 5'd16;

    typedef struct packed {
        t_uop   op;
        t_kind  kind;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic  in_valid;
        logic  out_free;
        t_disp disp;
        logic  tick_wait;
        logic  ack_advanced;
        logic  retry_left;
        logic  no_hit;
        logic  not_done;
        logic  more_frames;
    } t_ustat;

    // control from the sequencer to the datapath
    typedef struct packed {
        t_uop  op;
        t_kind kind;
        logic  go;
        logic  in_ready;
    } t_uctl;

    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = '{op: U_NOP, kind: KIND_FRAME, cond: C_ALWAYS, target: P_FETCH};
        case (pc)
            P_FETCH:     w = '{U_FETCH,  KIND_FRAME,      C_ALWAYS,       P_DECODE};
            P_DECODE:    w = '{U_DECODE, KIND_FRAME,      C_DISPATCH,     P_FETCH};
            P_BAD:       w = '{U_REPORT, KIND_BAD_STATE,  C_ALWAYS,       P_FETCH};
            P_ZERO:      w = '{U_REPORT, KIND_DONE,       C_ALWAYS,       P_FETCH};
            P_START:     w = '{U_START,  KIND_FRAME,      C_NEXT,         P_FETCH};
            P_BURST:     w = '{U_BURST,  KIND_FRAME,      C_NEXT,         P_FETCH};
            P_EMIT:      w = '{U_FRAME,  KIND_FRAME,      C_MORE_FRAMES,  P_EMIT};
            P_BURST_END: w = '{U_NOP,    KIND_FRAME,      C_ALWAYS,       P_FETCH};
            P_TICK:      w = '{U_TICK,   KIND_FRAME,      C_NEXT,         P_FETCH};
            P_TICK_CHK:  w = '{U_NOP,    KIND_FRAME,      C_TICK_WAIT,    P_FETCH};
            P_RESOLVE:   w = '{U_NOP,    KIND_FRAME,      C_ACK_ADVANCED, P_MATCH};
            P_RETRY:     w = '{U_RETRY,  KIND_FRAME,      C_RETRY_LEFT,   P_BURST};
            P_TIMEOUT:   w = '{U_FINISH, KIND_TIMEOUT,    C_ALWAYS,       P_FETCH};
            P_MATCH:     w = '{U_MATCH,  KIND_FRAME,      C_NO_HIT,       P_OOS};
            P_DONE_CHK:  w = '{U_NOP,    KIND_FRAME,      C_NOT_DONE,     P_BURST};
            P_DONE:      w = '{U_FINISH, KIND_DONE,       C_ALWAYS,       P_FETCH};
            P_OOS:       w = '{U_FINISH, KIND_OUT_OF_SEQ, C_ALWAYS,       P_FETCH};
            default:     w = '{U_NOP,    KIND_FRAME,      C_ALWAYS,       P_FETCH};
        endcase
        return w;
    endfunction

    function automatic t_upc disp_target(input t_disp d);
        t_upc pc;
        case (d)
            D_BAD:     pc = P_BAD;
            D_ZERO:    pc = P_ZERO;
            D_START:   pc = P_START;
            D_RESOLVE: pc = P_RESOLVE;
            D_TICK:    pc = P_TICK;
            default:   pc = P_FETCH;
        endcase
        return pc;
    endfunction

endpackage

/* hw/rtl/burst_ack_stream_sender_top.sv */
// burst ack stream sender: datapath, output register, config port and sequencer
// A small microcode program steps through every item one control word per clock, unless a
// fetch waits for input or a reporting step waits for the output register. An item with
// no result passes only fetch and decode; a tick that leaves the burst waiting also passes
// tick and tick-check. A bad-state or empty-write report adds a report step. A start passes
// start, burst, a frame step per descriptor and burst end. An ack that resolves the burst
// resends it or sends the next one, and so can a tick. Descriptors leave one per cycle from
// the frame step while the output register is free. The next item is taken once the
// program is back at its fetch step. A result waits in the output register without
// holding up the input, and a stalled output only stalls steps that report. The ack
// timeout register sits at byte address 0 of the APB-style port and resets to 1000.
module burst_ack_stream_sender_top import bass_pkg::*; #(
    parameter int FRAME_PAYLOAD = 64,
    parameter int BURST_FRAMES  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic [15:0]           i_write_length,
    input  logic                  i_link_open,
    input  logic [7:0]            i_ack_number,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_result_kind,
    output logic [7:0]            o_frame_seq,
    output logic [15:0]           o_frame_offset,
    output logic [6:0]            o_frame_bytes,
    output logic                  o_burst_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SLOT_W = (BURST_FRAMES > 1) ? $clog2(BURST_FRAMES) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BURST_FRAMES - 1);
    localparam logic [15:0] FP_LEN = 16'(FRAME_PAYLOAD);

    t_ustat stat;
    t_uctl  ctl;

    // config
    logic [31:0] r_timeout;
    logic        cfg_write;

    // latched input item
    t_action     r_act;
    logic [15:0] r_len;
    logic        r_open;
    logic [7:0]  r_ack;

    // connection and burst state
    logic [7:0]        r_conn_seq, n_conn_seq;
    logic [7:0]        r_last_ack, n_last_ack;
    logic [7:0]        r_tail_seq, n_tail_seq;
    logic [15:0]       r_pos, n_pos;
    logic [15:0]       r_burst_start, n_burst_start;
    logic [15:0]       r_total_len, n_total_len;
    logic [1:0]        r_retry, n_retry;
    logic [31:0]       r_wait, n_wait;
    logic              r_busy, n_busy;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [BURST_FRAMES-1:0] r_slot_valid, n_slot_valid;
    logic [7:0]        r_slot_seq [BURST_FRAMES];
    logic [15:0]       r_slot_end [BURST_FRAMES];

    // output register
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_seq;
    logic [15:0] r_out_offset;
    logic [6:0]  r_out_bytes;
    logic        r_out_last;
    logic        out_free;
    logic        out_load;

    // frame arithmetic
    logic [15:0]       rem;
    logic [15:0]       frame_cnt;
    logic [15:0]       frame_end;
    logic [7:0]        frame_seq;
    logic              more_frames;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              frame_wr;
    t_disp             disp;

    bass_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    assign o_in_ready = ctl.in_ready;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_ACK_TIMEOUT);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_ACK_TIMEOUT) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= ACK_TIMEOUT_RESET;
        end else if (cfg_write) begin
            r_timeout <= pwdata;
        end
    end

    assign rem         = r_total_len - r_pos;
    assign frame_cnt   = (rem < FP_LEN) ? rem : FP_LEN;
    assign frame_end   = r_pos + frame_cnt;
    assign frame_seq   = r_conn_seq + 8'(r_slot) + 8'd1;
    assign more_frames = (r_slot != LAST_SLOT) && (frame_end != r_total_len);

    // highest matching slot wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < BURST_FRAMES; i++) begin
            if (r_slot_valid[i] && (r_slot_seq[i] == r_last_ack)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        case (r_act)
            ACT_START: begin
                if (!r_open || r_busy) begin
                    disp = D_BAD;
                end else if (r_len == 16'd0) begin
                    disp = D_ZERO;
                end else begin
                    disp = D_START;
                end
            end
            ACT_ACK:  disp = (r_busy && (r_ack == r_tail_seq)) ? D_RESOLVE : D_IDLE;
            ACT_TICK: disp = r_busy ? D_TICK : D_IDLE;
            default:  disp = D_IDLE;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign stat.in_valid     = i_in_valid;
    assign stat.out_free     = out_free;
    assign stat.disp         = disp;
    assign stat.tick_wait    = (r_wait < r_timeout);
    assign stat.ack_advanced = (r_last_ack != r_conn_seq);
    assign stat.retry_left   = (r_retry != RETRY_FINAL);
    assign stat.no_hit       = !hit;
    assign stat.not_done     = (r_pos != r_total_len);
    assign stat.more_frames  = more_frames;

    assign out_load = ctl.go &&
                      (ctl.op == U_REPORT || ctl.op == U_FRAME || ctl.op == U_FINISH);
    assign frame_wr = ctl.go && (ctl.op == U_FRAME);

    always_comb begin
        n_conn_seq    = r_conn_seq;
        n_last_ack    = r_last_ack;
        n_tail_seq    = r_tail_seq;
        n_pos         = r_pos;
        n_burst_start = r_burst_start;
        n_total_len   = r_total_len;
        n_retry       = r_retry;
        n_wait        = r_wait;
        n_busy        = r_busy;
        n_slot        = r_slot;
        n_slot_valid  = r_slot_valid;
        n_out_valid   = r_out_valid && !i_out_ready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
        if (ctl.go) begin
            case (ctl.op)
                U_DECODE: begin
                    if (r_act == ACT_ACK) begin
                        n_last_ack = r_ack;
                    end
                end
                U_START: begin
                    n_busy      = 1'b1;
                    n_total_len = r_len;
                    n_pos       = 16'd0;
                    n_retry     = 2'd0;
                end
                U_BURST: begin
                    n_burst_start = r_pos;
                    n_wait        = 32'd0;
                    n_slot_valid  = '0;
                    n_slot        = '0;
                end
                U_FRAME: begin
                    n_slot_valid[r_slot] = 1'b1;
                    n_tail_seq           = frame_seq;
                    n_pos                = frame_end;
                    n_slot               = r_slot + 1'b1;
                end
                U_TICK: begin
                    // saturating tick counter
                    if (r_wait != '1) begin
                        n_wait = r_wait + 32'd1;
                    end
                end
                U_RETRY: begin
                    n_retry = r_retry + 2'd1;
                    n_pos   = r_burst_start;
                end
                U_MATCH: begin
                    if (hit) begin
                        n_pos      = r_slot_end[hit_idx];
                        n_conn_seq = r_conn_seq + 8'(hit_idx) + 8'd1;
                    end
                end
                U_FINISH: begin
                    n_busy       = 1'b0;
                    n_slot_valid = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn_seq    <= 8'd0;
            r_last_ack    <= 8'd0;
            r_tail_seq    <= 8'd0;
            r_pos         <= 16'd0;
            r_burst_start <= 16'd0;
            r_total_len   <= 16'd0;
            r_retry       <= 2'd0;
            r_wait        <= 32'd0;
            r_busy        <= 1'b0;
            r_slot        <= '0;
            r_slot_valid  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_conn_seq    <= n_conn_seq;
            r_last_ack    <= n_last_ack;
            r_tail_seq    <= n_tail_seq;
            r_pos         <= n_pos;
            r_burst_start <= n_burst_start;
            r_total_len   <= n_total_len;
            r_retry       <= n_retry;
            r_wait        <= n_wait;
            r_busy        <= n_busy;
            r_slot        <= n_slot;
            r_slot_valid  <= n_slot_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ctl.go && ctl.op == U_FETCH) begin
            r_act  <= t_action'(i_action);
            r_len  <= i_write_length;
            r_open <= i_link_open;
            r_ack  <= i_ack_number;
        end
        if (frame_wr) begin
            r_slot_seq[r_slot] <= frame_seq;
            r_slot_end[r_slot] <= frame_end;
        end
        if (out_load) begin
            r_out_kind <= ctl.kind;
            if (ctl.op == U_FRAME) begin
                r_out_seq    <= frame_seq;
                r_out_offset <= r_pos;
                r_out_bytes  <= frame_cnt[6:0];
                r_out_last   <= !more_frames;
            end else begin
                r_out_seq    <= 8'd0;
                r_out_offset <= (ctl.op == U_FINISH && ctl.kind == KIND_DONE) ?
                                r_total_len : 16'd0;
                r_out_bytes  <= 7'd0;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_frame_seq    = r_out_seq;
    assign o_frame_offset = r_out_offset;
    assign o_frame_bytes  = r_out_bytes;
    assign o_burst_last   = r_out_last;

`ifndef SYNTHESIS
    // no slot stays live once a write is over
    a_idle_slots_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_slot_valid == '0))
        else $error("slot valid while idle");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_total_len)
        else $error("send position beyond write length");

    a_frame_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_wr |-> (frame_cnt != 16'd0 && frame_cnt <= FP_LEN))
        else $error("frame byte count out of range");

    // a busy write with three retries is only ever reporting its timeout
    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_retry == 2'd3) |-> (ctl.op == U_FINISH))
        else $error("retry count reached limit without timeout");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result lost in output register");
`endif

endmodule

/* hw/rtl/bass_useq.sv */
// microcode sequencer: step counter, program lookup and jump logic
module bass_useq import bass_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ustat i_stat,
    output t_uctl  o_ctl
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uword;
    logic   go;
    logic   take;

    assign uword = ucode_rom(r_pc);

    always_comb begin
        case (uword.op)
            U_FETCH:                     go = i_stat.in_valid;
            U_REPORT, U_FRAME, U_FINISH: go = i_stat.out_free;
            default:                     go = 1'b1;
        endcase
    end

    always_comb begin
        case (uword.cond)
            C_ALWAYS:       take = 1'b1;
            C_TICK_WAIT:    take = i_stat.tick_wait;
            C_ACK_ADVANCED: take = i_stat.ack_advanced;
            C_RETRY_LEFT:   take = i_stat.retry_left;
            C_NO_HIT:       take = i_stat.no_hit;
            C_NOT_DONE:     take = i_stat.not_done;
            C_MORE_FRAMES:  take = i_stat.more_frames;
            default:        take = 1'b0;
        endcase
    end

    always_comb begin
        if (!go) begin
            n_pc = r_pc;
        end else if (uword.cond == C_DISPATCH) begin
            n_pc = disp_target(i_stat.disp);
        end else if (take) begin
            n_pc = uword.target;
        end else begin
            n_pc = r_pc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.op       = uword.op;
    assign o_ctl.kind     = uword.kind;
    assign o_ctl.go       = go;
    assign o_ctl.in_ready = (uword.op == U_FETCH);

endmodule
